// ----- rtl/glyph_text_blitter_page_fb_core_defines.svh -----
// Assertion helpers used by the blitter core.
`ifndef GLYPH_TEXT_BLITTER_PAGE_FB_CORE_DEFINES_SVH
`define GLYPH_TEXT_BLITTER_PAGE_FB_CORE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define GTB_ASSERT_HOLDS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define GTB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/gtb_pkg.sv -----
package gtb_pkg;

  localparam int DISP_WIDTH_DEF  = 128;
  localparam int DISP_HEIGHT_DEF = 64;
  localparam int GLYPH_COUNT_DEF = 5;

  localparam int ROM_GLYPHS  = 5;
  localparam int GLYPH_SIZE  = 16;
  localparam int GLYPH_PITCH = 17;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef logic [15:0] glyph_row_t;

  // Row-major: glyph * 16 + row, bit 15 is the leftmost column.
  localparam glyph_row_t GLYPH_ROM [0:ROM_GLYPHS*GLYPH_SIZE-1] = '{
    16'h0480, 16'h0EA0, 16'h7890, 16'h0890, 16'h0884, 16'hFFFE, 16'h0880, 16'h0890,
    16'h0A90, 16'h0C60, 16'h1840, 16'h68A0, 16'h0920, 16'h0A14, 16'h2814, 16'h100C,
    16'h0078, 16'h3F80, 16'h1110, 16'h0920, 16'h7FFE, 16'h4202, 16'h8204, 16'h7FF8,
    16'h0400, 16'h07F0, 16'h0A20, 16'h0940, 16'h1080, 16'h1160, 16'h221C, 16'h0C08,
    16'h0800, 16'h047C, 16'hFFC4, 16'h0044, 16'h3F48, 16'h2148, 16'h2150, 16'h3F48,
    16'h0044, 16'h7F42, 16'h0242, 16'h0462, 16'hFF54, 16'h0448, 16'h1440, 16'h0840,
    16'h0440, 16'h0444, 16'hFFFE, 16'h0440, 16'h0540, 16'h0100, 16'h0900, 16'h0910,
    16'h09F8, 16'h0900, 16'h0900, 16'h0900, 16'h0900, 16'h0904, 16'hFFFE, 16'h0000,
    16'h0820, 16'h7EFC, 16'h0820, 16'h3EF8, 16'h0820, 16'h7EFC, 16'h0820, 16'h3FF8,
    16'h0008, 16'hFFFE, 16'h0008, 16'h3FF8, 16'h0900, 16'h28A8, 16'h4824, 16'h07E0
  };

  // One read-modify-write beat: which page/column of which glyph.
  typedef struct packed {
    logic [4:0] page;
    logic [3:0] col;
    logic [2:0] glyph;
    logic       ink;
    logic [7:0] top;
  } beat_t;

  function automatic glyph_row_t glyph_row(input logic [2:0] g, input logic [3:0] r);
    glyph_row_t row;
    row = '0;
    if (32'(g) < ROM_GLYPHS) begin
      row = GLYPH_ROM[{g, r}];
    end
    return row;
  endfunction

endpackage

// ----- rtl/glyph_text_blitter_page_fb_core.sv -----
// Read item: the buffer byte is registered, latched in ST_READ and presented from ST_DONE.
// Draw item: per glyph drawn, an ST_GLYPH check and then 16 columns per page touched (2 or 3);
//   one buffer read-modify-write per cycle while in ST_BLIT.
//   A draw whose rows run off the bottom edge goes straight to ST_DONE.
// One item at a time; the next item is taken while the last result waits on out_stall.
// Reset (rst_n low, synchronous) starts a clearing pass over all DISP_WIDTH*DISP_HEIGHT/8
//   bytes (1024 by default) that zeroes the buffer while in_stall stays high.
`include "glyph_text_blitter_page_fb_core_defines.svh"

module glyph_text_blitter_page_fb_core #(
  parameter int DISP_WIDTH  = gtb_pkg::DISP_WIDTH_DEF,
  parameter int DISP_HEIGHT = gtb_pkg::DISP_HEIGHT_DEF,
  parameter int GLYPH_COUNT = gtb_pkg::GLYPH_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_op,
  input  logic [7:0] in_pos_x,
  input  logic [7:0] in_pos_y,
  input  logic       in_ink,
  input  logic [9:0] in_read_addr,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_byte,
  output logic [2:0] out_glyphs_drawn
);

  localparam int FB_BYTES = DISP_WIDTH * DISP_HEIGHT / 8;
  localparam int AW       = $clog2(FB_BYTES);
  localparam int GW       = $clog2(GLYPH_COUNT + 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_READ  = 6'b000100,
    ST_GLYPH = 6'b001000,
    ST_BLIT  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic           s1_valid_r, s1_valid_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [9:0]     left_r, left_nxt;
  logic [GW-1:0]  gi_r, gi_nxt;
  logic [2:0]     rom_r, rom_nxt;
  logic [2:0]     drawn_r, drawn_nxt;
  logic [4:0]     page_r, page_nxt;
  logic [4:0]     last_page_r, last_page_nxt;
  logic [3:0]     col_r, col_nxt;
  logic [7:0]     top_r, top_nxt;
  logic           ink_r, ink_nxt;
  logic           rd_ok_r, rd_ok_nxt;
  logic [7:0]     res_byte_r, res_byte_nxt;
  logic [AW-1:0]  s1_addr_r, s1_addr_nxt;
  gtb_pkg::beat_t s1_beat_r, s1_beat_nxt;
  logic [7:0]     out_read_byte_r, out_read_byte_nxt;
  logic [2:0]     out_glyphs_r, out_glyphs_nxt;

  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  blit_addr;
  logic [7:0]     rd_data_r;
  logic [7:0]     merged;
  logic           in_fire;
  logic           out_free;

  logic [7:0]     fb_mem [0:FB_BYTES-1];

  assign in_stall         = (state_r != ST_IDLE);
  assign in_fire          = in_valid && !in_stall;
  assign out_free         = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_read_byte    = out_read_byte_r;
  assign out_glyphs_drawn = out_glyphs_r;

  assign blit_addr = AW'(32'(page_r) * DISP_WIDTH + 32'(left_r) + 32'(col_r));

  gtb_pix_merge u_merge (
    .beat     (s1_beat_r),
    .old_byte (rd_data_r),
    .new_byte (merged)
  );

  always_comb begin
    state_nxt         = state_r;
    clr_cnt_nxt       = clr_cnt_r;
    s1_valid_nxt      = 1'b0;
    out_valid_nxt     = out_valid_r && out_stall;
    left_nxt          = left_r;
    gi_nxt            = gi_r;
    rom_nxt           = rom_r;
    drawn_nxt         = drawn_r;
    page_nxt          = page_r;
    last_page_nxt     = last_page_r;
    col_nxt           = col_r;
    top_nxt           = top_r;
    ink_nxt           = ink_r;
    rd_ok_nxt         = rd_ok_r;
    res_byte_nxt      = res_byte_r;
    s1_addr_nxt       = blit_addr;
    s1_beat_nxt       = '{page: page_r, col: col_r, glyph: rom_r, ink: ink_r, top: top_r};
    out_read_byte_nxt = out_read_byte_r;
    out_glyphs_nxt    = out_glyphs_r;
    rd_addr           = blit_addr;

    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(FB_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        rd_addr = AW'(in_read_addr);
        if (in_fire) begin
          drawn_nxt    = '0;
          res_byte_nxt = '0;
          if (in_op == gtb_pkg::OP_READ) begin
            rd_ok_nxt = (32'(in_read_addr) < FB_BYTES);
            state_nxt = ST_READ;
          end else begin
            top_nxt       = in_pos_y;
            ink_nxt       = in_ink;
            left_nxt      = 10'(in_pos_x);
            gi_nxt        = '0;
            rom_nxt       = '0;
            col_nxt       = '0;
            page_nxt      = in_pos_y[7:3];
            last_page_nxt = 5'((9'(in_pos_y) + 9'd15) >> 3);
            if (32'(in_pos_y) + gtb_pkg::GLYPH_SIZE > DISP_HEIGHT) begin
              state_nxt = ST_DONE;
            end else begin
              state_nxt = ST_GLYPH;
            end
          end
        end
      end
      ST_READ: begin
        res_byte_nxt = rd_ok_r ? rd_data_r : 8'd0;
        state_nxt    = ST_DONE;
      end
      ST_GLYPH: begin
        page_nxt = top_r[7:3];
        col_nxt  = '0;
        // stop after GLYPH_COUNT glyphs or at the first glyph that runs off the right edge
        if (32'(gi_r) == GLYPH_COUNT ||
            32'(left_r) + gtb_pkg::GLYPH_SIZE > DISP_WIDTH) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_BLIT;
        end
      end
      ST_BLIT: begin
        s1_valid_nxt = 1'b1;
        col_nxt      = col_r + 1'b1;
        if (col_r == 4'd15) begin
          if (page_r == last_page_r) begin
            gi_nxt    = GW'(gi_r + 1'b1);
            drawn_nxt = drawn_r + 1'b1;
            left_nxt  = left_r + 10'(gtb_pkg::GLYPH_PITCH);
            rom_nxt   = (rom_r == 3'(gtb_pkg::ROM_GLYPHS - 1)) ? 3'd0 : rom_r + 1'b1;
            state_nxt = ST_GLYPH;
          end else begin
            page_nxt = page_r + 1'b1;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          out_read_byte_nxt = res_byte_r;
          out_glyphs_nxt    = drawn_r;
          state_nxt         = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r          <= left_nxt;
    gi_r            <= gi_nxt;
    rom_r           <= rom_nxt;
    drawn_r         <= drawn_nxt;
    page_r          <= page_nxt;
    last_page_r     <= last_page_nxt;
    col_r           <= col_nxt;
    top_r           <= top_nxt;
    ink_r           <= ink_nxt;
    rd_ok_r         <= rd_ok_nxt;
    res_byte_r      <= res_byte_nxt;
    s1_addr_r       <= s1_addr_nxt;
    s1_beat_r       <= s1_beat_nxt;
    out_read_byte_r <= out_read_byte_nxt;
    out_glyphs_r    <= out_glyphs_nxt;
  end

  // Beats within one draw hit distinct bytes, so the write-back never meets its own read.
  always_ff @(posedge clk) begin
    if (state_r == ST_CLEAR) begin
      fb_mem[clr_cnt_r] <= 8'd0;
    end else if (s1_valid_r) begin
      fb_mem[s1_addr_r] <= merged;
    end
    rd_data_r <= fb_mem[rd_addr];
  end

  `GTB_ASSERT_HOLDS(a_wb_only_in_draw, s1_valid_r, state_r == ST_BLIT || state_r == ST_GLYPH, "write-back outside a draw")
  `GTB_ASSERT_NEXT(a_blit_issues_beat, state_r == ST_BLIT, s1_valid_r, "blit cycle without write-back")
  `GTB_ASSERT_HOLDS(a_blit_glyph_lim, state_r == ST_BLIT, 32'(gi_r) < GLYPH_COUNT, "glyph index past count")
  `GTB_ASSERT_HOLDS(a_clear_quiet, state_r == ST_CLEAR, in_stall && !out_valid_r, "activity during clear")
  `GTB_ASSERT_HOLDS(a_draw_zero_byte, out_valid_r && out_glyphs_r != 3'd0, out_read_byte_r == 8'd0, "draw result with data byte")

endmodule

// ----- rtl/gtb_pix_merge.sv -----
module gtb_pix_merge (
  input  gtb_pkg::beat_t beat,
  input  logic [7:0]     old_byte,
  output logic [7:0]     new_byte
);

  always_comb begin
    logic [7:0]          row_abs;
    logic [7:0]          rel;
    logic                hit;
    logic                on;
    gtb_pkg::glyph_row_t bits;
    new_byte = old_byte;
    for (int b = 0; b < 8; b++) begin
      row_abs = {beat.page[4:0], 3'(b)};
      rel     = row_abs - beat.top;
      hit     = (row_abs >= beat.top) && (rel < 8'd16);
      bits    = gtb_pkg::glyph_row(beat.glyph, rel[3:0]);
      on      = bits[4'd15 - beat.col];
      // set on foreground with ink, clear on background without ink
      if (hit) begin
        new_byte[b] = beat.ink ? (old_byte[b] | on) : (old_byte[b] & on);
      end
    end
  end

endmodule

// ----- tb/tb_glyph_text_blitter_page_fb_core.sv -----
module tb_glyph_text_blitter_page_fb_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB_BYTES    = gtb_pkg::DISP_WIDTH_DEF * gtb_pkg::DISP_HEIGHT_DEF / 8;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_TAIL  = 10;
  localparam int LONG_HOLD   = 600;

  typedef struct packed {
    logic       op;
    logic [7:0] pos_x;
    logic [7:0] pos_y;
    logic       ink;
    logic [9:0] read_addr;
    bit         drain_first;
  } blit_cmd_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [2:0] glyphs_drawn;
  } reply_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_op = gtb_pkg::OP_DRAW;
  logic [7:0] in_pos_x = '0;
  logic [7:0] in_pos_y = '0;
  logic       in_ink = 1'b0;
  logic [9:0] in_read_addr = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_read_byte;
  logic [2:0] out_glyphs_drawn;

  blit_cmd_t cmd_queue[$];
  reply_t    reply_fifo[$];
  logic [7:0] shadow_fb [0:FB_BYTES-1];

  int mismatches     = 0;
  int items_accepted = 0;
  int replies_seen   = 0;
  int draws_done     = 0;
  int glyph_total    = 0;
  int reads_done     = 0;
  int nonzero_reads  = 0;
  int cycle_count    = 0;

  glyph_text_blitter_page_fb_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_op            (in_op),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_ink           (in_ink),
    .in_read_addr     (in_read_addr),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_read_byte    (out_read_byte),
    .out_glyphs_drawn (out_glyphs_drawn)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    if (mismatches < 100) begin
      $display("[%0t] MISMATCH %s: got %0h, want %0h", $time, what, got, want);
    end
    mismatches++;
  endtask

  function automatic blit_cmd_t make_cmd(input logic op, input int x, input int y,
                                         input logic ink, input int addr,
                                         input bit drain);
    blit_cmd_t c;
    c.op          = op;
    c.pos_x       = 8'(x);
    c.pos_y       = 8'(y);
    c.ink         = ink;
    c.read_addr   = 10'(addr);
    c.drain_first = drain;
    return c;
  endfunction

  // Apply one accepted command to the shadow buffer and queue the reply it yields.
  function automatic void render_item(input blit_cmd_t c);
    reply_t      r;
    int          left, py, idx, drawn;
    logic [15:0] bits;
    logic [7:0]  mask;
    r = '0;
    if (c.op == gtb_pkg::OP_READ) begin
      r.read_byte = (c.read_addr < FB_BYTES) ? shadow_fb[c.read_addr] : 8'h00;
      reads_done++;
      if (r.read_byte != 8'h00) nonzero_reads++;
    end else begin
      drawn = 0;
      for (int g = 0; g < gtb_pkg::GLYPH_COUNT_DEF; g++) begin
        left = int'(c.pos_x) + g * gtb_pkg::GLYPH_PITCH;
        // stop at the first glyph that runs off the display
        if (left + gtb_pkg::GLYPH_SIZE > gtb_pkg::DISP_WIDTH_DEF ||
            int'(c.pos_y) + gtb_pkg::GLYPH_SIZE > gtb_pkg::DISP_HEIGHT_DEF)
          break;
        for (int row = 0; row < gtb_pkg::GLYPH_SIZE; row++) begin
          bits = gtb_pkg::GLYPH_ROM[(g % gtb_pkg::ROM_GLYPHS) * gtb_pkg::GLYPH_SIZE + row];
          py   = int'(c.pos_y) + row;
          mask = 8'(1 << (py % 8));
          for (int col = 0; col < gtb_pkg::GLYPH_SIZE; col++) begin
            idx = (py / 8) * gtb_pkg::DISP_WIDTH_DEF + left + col;
            if (idx >= FB_BYTES) continue;
            if (bits[15-col] && c.ink)
              shadow_fb[idx] = shadow_fb[idx] | mask;
            else if (!bits[15-col] && !c.ink)
              shadow_fb[idx] = shadow_fb[idx] & ~mask;
          end
        end
        drawn++;
      end
      r.glyphs_drawn = 3'(drawn);
      draws_done++;
      glyph_total += drawn;
    end
    reply_fifo.push_back(r);
  endfunction

  // Driver: present queued commands, with random gaps and drain points.
  blit_cmd_t cur_cmd;
  int        send_gap = 0;
  bit        fast_send = 1'b0;

  always @(posedge clk) begin
    logic next_valid;
    int   roll;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      for (int i = 0; i < FB_BYTES; i++) shadow_fb[i] = 8'h00;
    end else begin
      next_valid = in_valid;
      if (in_valid && !in_stall) begin
        render_item(cur_cmd);
        items_accepted++;
        next_valid = 1'b0;
        roll = $urandom_range(0, 99);
        if (fast_send)     send_gap = 0;
        else if (roll < 60) send_gap = 0;
        else if (roll < 90) send_gap = $urandom_range(1, 4);
        else if (roll < 98) send_gap = $urandom_range(5, 30);
        else                send_gap = $urandom_range(60, 300);
        if ($urandom_range(0, 99) == 0) fast_send = !fast_send;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain_first && reply_fifo.size() != 0)) begin
          cur_cmd = cmd_queue.pop_front();
          in_op        <= cur_cmd.op;
          in_pos_x     <= cur_cmd.pos_x;
          in_pos_y     <= cur_cmd.pos_y;
          in_ink       <= cur_cmd.ink;
          in_read_addr <= cur_cmd.read_addr;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // Receiver stall: random short stalls, quiet stretches and a few long holds.
  int stall_left = 0;
  int long_hold_left = 0;
  int next_long_hold_at = 150;
  bit quiet_recv = 1'b0;

  always @(posedge clk) begin
    int roll;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (long_hold_left > 0) begin
        long_hold_left--;
      end else if (items_accepted >= next_long_hold_at) begin
        long_hold_left = LONG_HOLD;
        next_long_hold_at += 700;
      end
      if (stall_left > 0) begin
        stall_left--;
      end else if (!quiet_recv) begin
        roll = $urandom_range(0, 99);
        if (roll >= 95)      stall_left = $urandom_range(20, 80);
        else if (roll >= 70) stall_left = $urandom_range(1, 4);
      end
      if ($urandom_range(0, 149) == 0) quiet_recv = !quiet_recv;
      out_stall <= (long_hold_left > 0) || (stall_left > 0);
    end
  end

  // Monitor: compare each accepted result beat with the oldest queued reply.
  always @(posedge clk) begin
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (reply_fifo.size() == 0) begin
        report_mismatch("unexpected result beat, read_byte", 16'(out_read_byte), 16'h0);
      end else begin
        want = reply_fifo.pop_front();
        if (out_read_byte !== want.read_byte)
          report_mismatch("read_byte", 16'(out_read_byte), 16'(want.read_byte));
        if (out_glyphs_drawn !== want.glyphs_drawn)
          report_mismatch("glyphs_drawn", 16'(out_glyphs_drawn), 16'(want.glyphs_drawn));
        replies_seen++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
               reply_fifo.size());
      $display("glyph_text_blitter_page_fb_core test failed");
      $finish;
    end
  end

  initial begin : stimulus
    blit_cmd_t c;
    // directed: empty buffer, string fit limits, three-page rows, clearing ink
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 255, 255, 1'b1, 1023, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 0, 0, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 133, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 44, 3, 1'b1, 1023, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 45, 3, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 112, 48, 1'b1, 1023, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 113, 48, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 0, 49, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 255, 255, 1'b0, 1023, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 1023, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 0, 0, 1'b0, 0, 1'b1));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 5, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 130, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 60, 20, 1'b0, 1023, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 255, 255, 1'b1, 512, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 96, 0, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 95, 0, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_DRAW, 128, 0, 1'b1, 0, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 700, 1'b0));
    cmd_queue.push_back(make_cmd(gtb_pkg::OP_READ, 0, 0, 1'b0, 300, 1'b0));

    // random: mostly on-screen draws, the rest anywhere; reads over the whole range
    for (int n = 0; n < 1527; n++) begin
      c.op        = ($urandom_range(0, 99) < 35) ? gtb_pkg::OP_DRAW : gtb_pkg::OP_READ;
      c.ink       = 1'($urandom_range(0, 1));
      c.read_addr = 10'($urandom_range(0, 1023));
      if ($urandom_range(0, 9) < 8) begin
        c.pos_x = 8'($urandom_range(0, gtb_pkg::DISP_WIDTH_DEF - gtb_pkg::GLYPH_SIZE));
        c.pos_y = 8'($urandom_range(0, gtb_pkg::DISP_HEIGHT_DEF - gtb_pkg::GLYPH_SIZE));
      end else begin
        c.pos_x = 8'($urandom_range(0, 255));
        c.pos_y = 8'($urandom_range(0, 255));
      end
      c.drain_first = (n % 400 == 399);
      cmd_queue.push_back(c);
    end

    @(posedge clk);
    while (!rst_n || cmd_queue.size() != 0 || in_valid || reply_fifo.size() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    $display("covered %0d draw commands rendering %0d glyphs and %0d byte reads (%0d nonzero)",
             draws_done, glyph_total, reads_done, nonzero_reads);
    $display("%0d result beats checked over %0d cycles, %0d mismatches",
             replies_seen, cycle_count, mismatches);
    if (mismatches == 0) begin
      $display("glyph_text_blitter_page_fb_core test passed");
    end else begin
      $display("glyph_text_blitter_page_fb_core test failed");
    end
    $finish;
  end

endmodule

// ----- glyph_text_blitter_page_fb_core.f -----
+incdir+rtl
rtl/gtb_pkg.sv
rtl/gtb_pix_merge.sv
rtl/glyph_text_blitter_page_fb_core.sv
tb/tb_glyph_text_blitter_page_fb_core.sv
